/* hw/rtl/first_fit_free_list_allocator_defines.svh */
// Assertion macros shared by the allocator RTL.
// Users must have clk and arst_n in scope where a macro is expanded.
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define FFA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define FFA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/ffa_pkg.sv */
// Shared types and constants of the first-fit free-list allocator.
// No dependencies; used by the interfaces, controller, datapath and top level.
package ffa_pkg;

	localparam int SIZE_W = 11;
	localparam int ADDR_W = 10;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam logic STS_OK   = 1'b0;
	localparam logic STS_FAIL = 1'b1;

	typedef struct packed {
		logic load;
		logic step;
		logic commit;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic stream_done;
		logic out_full;
	} sts_t;

endpackage

/* hw/rtl/ffa_if.sv */
// Valid/ready channel interfaces for allocator requests and results.
// Depends on ffa_pkg for the field widths.
interface ffa_req_if ();
	logic                        valid;
	logic                        ready;
	logic                        req_type;
	logic [ffa_pkg::SIZE_W-1:0]  size;
	logic [ffa_pkg::ADDR_W-1:0]  addr;

	modport source (output valid, output req_type, output size, output addr, input ready);
	modport sink (input valid, input req_type, input size, input addr, output ready);
endinterface

interface ffa_rsp_if ();
	logic                        valid;
	logic                        ready;
	logic                        status;
	logic [ffa_pkg::ADDR_W-1:0]  alloc_addr;

	modport source (output valid, output status, output alloc_addr, input ready);
	modport sink (input valid, input status, input alloc_addr, output ready);
endinterface

/* hw/rtl/ffa_ctrl.sv */
// Controller state machine of the allocator: sequences load, table pass,
// commit and result hand-off. Depends on ffa_pkg and the assertion macros.
`include "first_fit_free_list_allocator_defines.svh"

module ffa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output ffa_pkg::cmd_t cmd,
	input  ffa_pkg::sts_t sts
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_RUN    = 2'd1;
	localparam logic [1:0] S_COMMIT = 2'd2;
	localparam logic [1:0] S_OUT    = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_RUN;
				end
			end
			S_RUN: begin
				if (sts.skip) begin
					state_d = S_OUT;
				end else if (sts.stream_done) begin
					state_d = S_COMMIT;
				end else begin
					cmd.step = 1'b1;
				end
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = S_OUT;
			end
			S_OUT: begin
				if (!sts.out_full) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`FFA_ASSERT_NXT(a_load_starts_run, cmd.load, state_q == S_RUN, "accepted request did not start a pass")

endmodule

/* hw/rtl/ffa_dpath.sv */
// Datapath of the allocator: segment table memory, streaming rewrite pass
// with insert, first-fit grant and merge, and the result register.
// Depends on ffa_pkg and the assertion macros.
`include "first_fit_free_list_allocator_defines.svh"

module ffa_dpath #(
	parameter int MEM_WORDS = 1024,
	parameter int MAX_SEGS  = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ffa_pkg::cmd_t              cmd,
	output ffa_pkg::sts_t              sts,
	input  logic                       req_type,
	input  logic [ffa_pkg::SIZE_W-1:0] size,
	input  logic [ffa_pkg::ADDR_W-1:0] addr,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output logic                       status,
	output logic [ffa_pkg::ADDR_W-1:0] alloc_addr
);

	localparam int SW = $clog2(MEM_WORDS);
	localparam int LW = (SW + 1 > ffa_pkg::SIZE_W + 1) ? SW + 1 : ffa_pkg::SIZE_W + 1;
	localparam int CW = $clog2(MAX_SEGS + 1);
	localparam int IW = $clog2(MAX_SEGS);
	localparam logic [LW-1:0] MEM_TOP = LW'(MEM_WORDS - 1);
	localparam logic [LW-1:0] MEM_LIM = LW'(MEM_WORDS);

	typedef struct packed {
		logic [SW-1:0] lo;
		logic [SW-1:0] hi;
	} seg_t;

	localparam seg_t RESET_SEG = '{lo: '0, hi: MEM_TOP[SW-1:0]};

	seg_t mem_q [MAX_SEGS];

	logic          free_q;
	logic [LW-1:0] size_q;
	seg_t          new_q;
	logic          skip_q;
	logic          pre_st_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] ra_q;
	logic [CW-1:0] w_q;
	logic          rv_q;
	logic          rd_fresh_q;
	seg_t          rd_q;
	seg_t          cur_q;
	logic          have_q;
	logic          ins_q;
	logic          hit_q;
	logic [SW-1:0] grant_q;
	logic          fresh_q;
	logic          out_v_q;
	logic          out_st_q;
	logic [ffa_pkg::ADDR_W-1:0] out_addr_q;

	logic [LW-1:0] addr_x;
	logic [LW-1:0] size_x;
	logic [LW-1:0] last_x;
	logic [LW-1:0] last_c;
	logic          addr_bad;
	logic          full;
	logic          is_free;
	seg_t          new_d;

	seg_t          rd_eff;
	logic [LW-1:0] rd_len;
	logic [LW-1:0] adv;
	logic          take_alloc;
	logic          exact;
	logic          inject;
	logic          consume;
	logic          issue;
	seg_t          elem;
	logic          push;
	logic          touch;
	logic          wr_en;
	logic [IW-1:0] wr_idx;
	logic [LW-1:0] grant_x;

	// Request decode at accept time.
	always_comb begin
		addr_x   = LW'(addr);
		size_x   = LW'(size);
		last_x   = addr_x + size_x - LW'(1);
		last_c   = (last_x > MEM_TOP) ? MEM_TOP : last_x;
		addr_bad = (addr_x >= MEM_LIM);
		full     = (cnt_q >= CW'(MAX_SEGS));
		is_free  = (req_type == ffa_pkg::REQ_FREE);
		new_d.lo = addr_x[SW-1:0];
		new_d.hi = last_c[SW-1:0];
	end

	// One element of the table pass per cycle.
	always_comb begin
		rd_eff     = rd_fresh_q ? RESET_SEG : rd_q;
		rd_len     = LW'(rd_eff.hi) - LW'(rd_eff.lo) + LW'(1);
		adv        = LW'(rd_eff.lo) + size_q;
		take_alloc = !free_q && rv_q && !hit_q && (rd_len >= size_q);
		exact      = (rd_len == size_q);
		if (rv_q) begin
			inject = free_q && !ins_q && (LW'(rd_eff.lo) >= LW'(new_q.lo));
		end else begin
			inject = free_q && !ins_q && (ra_q == cnt_q);
		end
		consume = rv_q && !inject;
		issue   = (ra_q < cnt_q) && (!rv_q || consume);
		if (inject) begin
			elem = new_q;
		end else if (take_alloc) begin
			elem.lo = adv[SW-1:0];
			elem.hi = rd_eff.hi;
		end else begin
			elem = rd_eff;
		end
		push   = inject || (consume && !(take_alloc && exact));
		touch  = free_q && ((LW'(cur_q.hi) + LW'(1)) == LW'(elem.lo));
		wr_en  = (cmd.step && push && have_q && !touch) || (cmd.commit && have_q);
		wr_idx = w_q[IW-1:0];
	end

	always_comb begin
		sts.skip        = skip_q;
		sts.stream_done = !rv_q && (ra_q == cnt_q) && (!free_q || ins_q);
		sts.out_full    = out_v_q && !rsp_ready;
	end

	// Segment table; entry 0 reads as the full-memory segment until written.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx] <= cur_q;
		end
		if (cmd.step && issue) begin
			rd_q <= mem_q[ra_q[IW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q     <= 1'b0;
			skip_q     <= 1'b0;
			pre_st_q   <= ffa_pkg::STS_OK;
			cnt_q      <= CW'(1);
			ra_q       <= '0;
			w_q        <= '0;
			rv_q       <= 1'b0;
			rd_fresh_q <= 1'b0;
			have_q     <= 1'b0;
			ins_q      <= 1'b0;
			hit_q      <= 1'b0;
			fresh_q    <= 1'b1;
			out_v_q    <= 1'b0;
		end else begin
			if (wr_en && (wr_idx == '0)) begin
				fresh_q <= 1'b0;
			end
			if (cmd.load) begin
				free_q   <= is_free;
				skip_q   <= is_free && (addr_bad || (size == '0) || full);
				pre_st_q <= (is_free && (addr_bad || ((size != '0) && full))) ?
					ffa_pkg::STS_FAIL : ffa_pkg::STS_OK;
				ra_q     <= '0;
				w_q      <= '0;
				rv_q     <= 1'b0;
				have_q   <= 1'b0;
				ins_q    <= 1'b0;
				hit_q    <= 1'b0;
			end
			if (cmd.step) begin
				if (issue) begin
					ra_q       <= ra_q + CW'(1);
					rd_fresh_q <= fresh_q && (ra_q == '0);
					rv_q       <= 1'b1;
				end else if (consume) begin
					rv_q <= 1'b0;
				end
				if (inject) begin
					ins_q <= 1'b1;
				end
				if (take_alloc) begin
					hit_q <= 1'b1;
				end
				if (push) begin
					if (!have_q) begin
						have_q <= 1'b1;
					end else if (!touch) begin
						w_q <= w_q + CW'(1);
					end
				end
			end
			if (cmd.commit) begin
				cnt_q <= w_q + CW'(have_q);
			end
			if (cmd.emit) begin
				out_v_q <= 1'b1;
			end else if (rsp_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_comb begin
		grant_x = LW'(grant_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			size_q <= size_x;
			new_q  <= new_d;
		end
		if (cmd.step) begin
			if (take_alloc) begin
				grant_q <= rd_eff.lo;
			end
			if (push) begin
				if (have_q && touch) begin
					cur_q.hi <= elem.hi;
				end else begin
					cur_q <= elem;
				end
			end
		end
		if (cmd.emit) begin
			if (free_q) begin
				out_st_q   <= pre_st_q;
				out_addr_q <= '0;
			end else begin
				out_st_q   <= hit_q ? ffa_pkg::STS_OK : ffa_pkg::STS_FAIL;
				out_addr_q <= hit_q ? grant_x[ffa_pkg::ADDR_W-1:0] : '0;
			end
		end
	end

	assign rsp_valid  = out_v_q;
	assign status     = out_st_q;
	assign alloc_addr = out_addr_q;

	`FFA_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= CW'(MAX_SEGS), "segment count above table depth")
	`FFA_ASSERT_IMP(a_wr_behind_rd, cmd.step && wr_en && rv_q, w_q < ra_q, "write overtook unread entry")
	`FFA_ASSERT_IMP(a_hit_on_alloc, hit_q, !free_q, "grant recorded during a free")
	`FFA_ASSERT_IMP(a_emit_room, cmd.emit, !out_v_q || rsp_ready, "result overwrote a pending beat")

endmodule

/* hw/rtl/first_fit_free_list_allocator.sv */
// First-fit free-list allocator, top level.
// Depends on ffa_pkg, ffa_if, ffa_ctrl and ffa_dpath.
//
// Requests arrive on req as beats of req_type, size and addr; every request
// gives exactly one result beat on rsp with status and alloc_addr. An
// allocate grants the start of the first free segment long enough for size;
// a free inserts [addr, addr+size-1] in start order and merges touching
// segments. The free table lives in a one-write, one-read memory of MAX_SEGS
// entries and is rewritten in one streaming pass per request that passes its
// checks. One request is in flight at a time. A pass covers the table at one
// entry per cycle, the rate at which the table memory port can deliver
// entries; a free rejected by its checks skips the pass. The next request is
// taken once the result sits in the output register, so a stalled receiver
// holds at most one finished beat while the next pass proceeds. A further
// result waits until that beat is taken.
// Reset clears the control state and leaves one segment covering all
// MEM_WORDS words; no clearing pass is needed.
module first_fit_free_list_allocator #(
	parameter int MEM_WORDS = 1024,
	parameter int MAX_SEGS  = 64
) (
	input logic       clk,
	input logic       arst_n,
	ffa_req_if.sink   req,
	ffa_rsp_if.source rsp
);

	ffa_pkg::cmd_t cmd;
	ffa_pkg::sts_t sts;

	ffa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	ffa_dpath #(
		.MEM_WORDS (MEM_WORDS),
		.MAX_SEGS  (MAX_SEGS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.req_type   (req.req_type),
		.size       (req.size),
		.addr       (req.addr),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.status     (rsp.status),
		.alloc_addr (rsp.alloc_addr)
	);

endmodule
